// ===== src/sample_set_statistics_unit_assert.svh =====
// Assertion macros shared by the statistics unit.
// Each use stands on a line of its own and needs no trailing semicolon.
`ifndef SAMPLE_SET_STATISTICS_UNIT_ASSERT_SVH
`define SAMPLE_SET_STATISTICS_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sss_pkg.sv =====
`timescale 1ns / 1ps

package sss_pkg;

  // Set capacity and the widths that follow from it.
  localparam int MAX_SAMPLES = 128;
  localparam int SAMPLE_W    = 16;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W       = SAMPLE_W + CNT_W;
  localparam int SQS_W       = 2 * SAMPLE_W + CNT_W;
  localparam int SQ_W        = 2 * SUM_W;
  localparam int RAD_W       = SQS_W + (SQS_W % 2);
  localparam int ROOT_W      = RAD_W / 2;
  localparam int OP_W        = SQ_W;
  localparam int REM_W       = ROOT_W + 3;
  localparam int STEP_W      = $clog2(OP_W);
  localparam int COUNT_W     = 8;
  localparam int STATUS_W    = 2;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_SINGLE  = 2'd1,
    STATUS_DROPPED = 2'd2
  } status_e;

  // Operation of the shared divide and square-root unit.
  typedef enum logic {
    MODE_DIV,
    MODE_SQRT
  } iter_mode_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN_GO,
    ST_MEAN_WT,
    ST_QUO_GO,
    ST_QUO_WT,
    ST_VAR_GO,
    ST_VAR_WT,
    ST_ROOT_GO,
    ST_ROOT_WT,
    ST_LOAD
  } seq_state_e;

  // Input item.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } sample_in_t;

  // Result item.
  typedef struct packed {
    logic [COUNT_W-1:0]  sample_count;
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] std_dev;
    logic [SAMPLE_W-1:0] largest;
    logic [SAMPLE_W-1:0] smallest;
    logic [STATUS_W-1:0] status;
  } stats_out_t;

  // Running set totals handed from the accumulator to the sequencer.
  typedef struct packed {
    logic [CNT_W-1:0]    cnt;
    logic [SUM_W-1:0]    sum;
    logic [SQS_W-1:0]    sumsq;
    logic [SAMPLE_W-1:0] largest;
    logic [SAMPLE_W-1:0] smallest;
    logic                ovf;
  } set_snapshot_t;

  // Command to the shared unit.
  typedef struct packed {
    logic       start;
    iter_mode_e mode;
  } iter_cmd_t;

  // Status of the shared unit.
  typedef struct packed {
    logic busy;
    logic done;
  } iter_stat_t;

endpackage

// ===== src/sample_set_statistics_unit.sv =====
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i / in_stall_o    sample_in_t  (sample, last)
// output    out        out_valid_o / out_stall_i  stats_out_t  (count, mean, std_dev, ...)
//
// A sample that is not the last of its set is taken at once, without a stall.
// The last sample holds the input stalled while the result is computed: three
// 48-step divides and a 20-step square root at one bit a cycle (only the mean
// divide for a single-sample set), each with a start and a wait state, then a load.
// The load waits while the previous result is still stalled at the output.
// Reset clears the running totals and the output valid; no clearing pass is needed.
`timescale 1ns / 1ps
`include "sample_set_statistics_unit_assert.svh"

module sample_set_statistics_unit import sss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  sample_in_t in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output stats_out_t out_data_o
);

  logic             in_accept;
  set_snapshot_t    snap;
  iter_cmd_t        iter_cmd;
  iter_stat_t       iter_stat;
  logic [OP_W-1:0]  operand;
  logic [CNT_W-1:0] divisor;
  logic [OP_W-1:0]  quo;
  logic [REM_W-1:0] rem;
  logic             single_dev;
  logic             extremes_ok;

  assign in_accept = in_valid_i && !in_stall_o;

  // Running totals of the current set.
  sss_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_data_i),
    .snap_o   (snap)
  );

  // Shared divide and square-root unit.
  sss_iter_unit u_iter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (iter_cmd),
    .operand_i (operand),
    .divisor_i (divisor),
    .stat_o    (iter_stat),
    .quo_o     (quo),
    .rem_o     (rem)
  );

  // Sequencer and output register.
  sss_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .capture_i   (in_accept && in_data_i.last),
    .snap_i      (snap),
    .iter_stat_i (iter_stat),
    .quo_i       (quo),
    .rem_i       (rem),
    .iter_cmd_o  (iter_cmd),
    .operand_o   (operand),
    .divisor_o   (divisor),
    .busy_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Result properties checked below.
  assign single_dev  = (out_data_o.status == STATUS_SINGLE) && (out_data_o.std_dev != '0);
  assign extremes_ok = out_data_o.smallest <= out_data_o.largest;

  // The shared unit only runs while the input is held off.
  `SSS_ASSERT_NOW(a_iter_idle, clk_i, rst_ni, !in_stall_o, !iter_stat.busy, "shared unit busy")
  // A new result only follows a computation.
  `SSS_ASSERT_NOW(a_res_src, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "stray result")
  // A single-sample set reports no deviation.
  `SSS_ASSERT_NOW(a_single_dev, clk_i, rst_ni, out_valid_o, !single_dev, "single with deviation")
  // Extremes are ordered in every result.
  `SSS_ASSERT_NOW(a_extremes, clk_i, rst_ni, out_valid_o, extremes_ok, "smallest above largest")

endmodule

// ===== src/sss_accum.sv =====
`timescale 1ns / 1ps

module sss_accum import sss_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  sample_in_t    item_i,
  output set_snapshot_t snap_o
);

  set_snapshot_t             acc_q;
  set_snapshot_t             acc_d;
  logic                      room;
  logic [2*SAMPLE_W-1:0]     square;

  // Fold the incoming sample into the totals unless the set is full.
  always_comb begin
    room   = acc_q.cnt < CNT_W'(MAX_SAMPLES);
    square = item_i.sample * item_i.sample;
    acc_d  = acc_q;
    if (room) begin
      acc_d.cnt   = acc_q.cnt + CNT_W'(1);
      acc_d.sum   = acc_q.sum + SUM_W'(item_i.sample);
      acc_d.sumsq = acc_q.sumsq + SQS_W'(square);
      if (item_i.sample > acc_q.largest) begin
        acc_d.largest = item_i.sample;
      end
      if (item_i.sample < acc_q.smallest) begin
        acc_d.smallest = item_i.sample;
      end
    end else begin
      acc_d.ovf = 1'b1;
    end
  end

  // The last item of a set hands the totals over and starts a fresh set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q.cnt      <= '0;
      acc_q.sum      <= '0;
      acc_q.sumsq    <= '0;
      acc_q.largest  <= '0;
      acc_q.smallest <= '1;
      acc_q.ovf      <= 1'b0;
    end else if (accept_i) begin
      if (item_i.last) begin
        acc_q.cnt      <= '0;
        acc_q.sum      <= '0;
        acc_q.sumsq    <= '0;
        acc_q.largest  <= '0;
        acc_q.smallest <= '1;
        acc_q.ovf      <= 1'b0;
      end else begin
        acc_q <= acc_d;
      end
    end
  end

  assign snap_o = acc_d;

endmodule

// ===== src/sss_iter_unit.sv =====
`timescale 1ns / 1ps

module sss_iter_unit import sss_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  iter_cmd_t        cmd_i,
  input  logic [OP_W-1:0]  operand_i,
  input  logic [CNT_W-1:0] divisor_i,
  output iter_stat_t       stat_o,
  output logic [OP_W-1:0]  quo_o,
  output logic [REM_W-1:0] rem_o
);

  logic              busy_q;
  logic              done_q;
  iter_mode_e        mode_q;
  logic [STEP_W-1:0] step_q;
  logic [STEP_W-1:0] last_step_q;
  logic [OP_W-1:0]   op_q;
  logic [OP_W-1:0]   op_d;
  logic [REM_W-1:0]  rem_q;
  logic [OP_W-1:0]   quo_q;
  logic [CNT_W-1:0]  dvsr_q;
  logic [REM_W-1:0]  shifted;
  logic [REM_W-1:0]  trial;
  logic              fits;

  // One restoring step: a quotient bit per cycle, or a root bit per cycle.
  always_comb begin
    if (mode_q == MODE_SQRT) begin
      shifted = {rem_q[REM_W-3:0], op_q[OP_W-1 -: 2]};
      trial   = {quo_q[REM_W-3:0], 2'b01};
      op_d    = {op_q[OP_W-3:0], 2'b00};
    end else begin
      shifted = {rem_q[REM_W-2:0], op_q[OP_W-1]};
      trial   = REM_W'(dvsr_q);
      op_d    = {op_q[OP_W-2:0], 1'b0};
    end
    fits = shifted >= trial;
  end

  // Step counter and handshake with the sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
      mode_q      <= MODE_DIV;
      step_q      <= '0;
      last_step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == last_step_q);
      if (cmd_i.start) begin
        busy_q      <= 1'b1;
        mode_q      <= cmd_i.mode;
        step_q      <= '0;
        last_step_q <= (cmd_i.mode == MODE_SQRT) ? STEP_W'(ROOT_W - 1) : STEP_W'(OP_W - 1);
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == last_step_q) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Operand, partial remainder and result shift registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q   <= operand_i;
      rem_q  <= '0;
      quo_q  <= '0;
      dvsr_q <= divisor_i;
    end else if (busy_q) begin
      op_q  <= op_d;
      rem_q <= fits ? (shifted - trial) : shifted;
      quo_q <= {quo_q[OP_W-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;
  assign rem_o       = rem_q;

endmodule

// ===== src/sss_seq.sv =====
`timescale 1ns / 1ps

module sss_seq import sss_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             capture_i,
  input  set_snapshot_t    snap_i,
  input  iter_stat_t       iter_stat_i,
  input  logic [OP_W-1:0]  quo_i,
  input  logic [REM_W-1:0] rem_i,
  output iter_cmd_t        iter_cmd_o,
  output logic [OP_W-1:0]  operand_o,
  output logic [CNT_W-1:0] divisor_o,
  output logic             busy_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output stats_out_t       out_data_o
);

  localparam logic [SAMPLE_W-1:0] DevMax = '1;

  seq_state_e          state_q;
  seq_state_e          state_d;
  set_snapshot_t       snap_q;
  logic [SAMPLE_W-1:0] mean_q;
  logic [SQ_W-1:0]     sq_q;
  logic [SQ_W-1:0]     sum_sq;
  logic [SQS_W-1:0]    sd_q;
  logic [SQS_W-1:0]    sd_d;
  logic [OP_W-1:0]     sumsq_ext;
  logic [OP_W-1:0]     sd_diff;
  logic [ROOT_W-1:0]   root;
  logic [SAMPLE_W-1:0] dev_q;
  logic                single;
  logic                load;
  stats_out_t          out_q;
  logic                out_valid_q;
  status_e             status;

  assign single = snap_q.cnt == CNT_W'(1);
  assign load   = (state_q == ST_LOAD) && (!out_valid_q || !out_stall_i);
  assign busy_o = state_q != ST_IDLE;

  // Next state and commands to the shared unit.
  always_comb begin
    state_d         = state_q;
    iter_cmd_o      = '{start: 1'b0, mode: MODE_DIV};
    operand_o       = '0;
    divisor_o       = snap_q.cnt;
    unique case (state_q)
      ST_IDLE: begin
        if (capture_i) begin
          state_d = ST_MEAN_GO;
        end
      end
      ST_MEAN_GO: begin
        iter_cmd_o.start = 1'b1;
        operand_o        = OP_W'(snap_q.sum);
        state_d          = ST_MEAN_WT;
      end
      ST_MEAN_WT: begin
        if (iter_stat_i.done) begin
          state_d = single ? ST_LOAD : ST_QUO_GO;
        end
      end
      ST_QUO_GO: begin
        iter_cmd_o.start = 1'b1;
        operand_o        = OP_W'(sq_q);
        state_d          = ST_QUO_WT;
      end
      ST_QUO_WT: begin
        if (iter_stat_i.done) begin
          state_d = ST_VAR_GO;
        end
      end
      ST_VAR_GO: begin
        iter_cmd_o.start = 1'b1;
        operand_o        = OP_W'(sd_q);
        divisor_o        = snap_q.cnt - CNT_W'(1);
        state_d          = ST_VAR_WT;
      end
      ST_VAR_WT: begin
        if (iter_stat_i.done) begin
          state_d = ST_ROOT_GO;
        end
      end
      ST_ROOT_GO: begin
        iter_cmd_o.start = 1'b1;
        iter_cmd_o.mode  = MODE_SQRT;
        operand_o        = {RAD_W'(sd_q), {(OP_W - RAD_W){1'b0}}};
        state_d          = ST_ROOT_WT;
      end
      ST_ROOT_WT: begin
        if (iter_stat_i.done) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Square of the sum, and sumsq minus floor(sum^2 / n), less one when the
  // division left a remainder.
  assign sum_sq    = snap_q.sum * snap_q.sum;
  assign sumsq_ext = OP_W'(snap_q.sumsq);
  assign sd_diff   = sumsq_ext - quo_i - OP_W'(rem_i != '0);
  assign sd_d      = (sumsq_ext > quo_i) ? SQS_W'(sd_diff) : '0;
  assign root      = quo_i[ROOT_W-1:0];

  // Working registers of the result.
  always_ff @(posedge clk_i) begin
    if (capture_i && (state_q == ST_IDLE)) begin
      snap_q <= snap_i;
    end
    if (state_q == ST_MEAN_GO) begin
      sq_q <= sum_sq;
    end
    if (iter_stat_i.done) begin
      unique case (state_q)
        ST_MEAN_WT: begin
          mean_q <= SAMPLE_W'(quo_i);
          dev_q  <= '0;
        end
        ST_QUO_WT: begin
          sd_q <= sd_d;
        end
        ST_VAR_WT: begin
          sd_q <= SQS_W'(quo_i);
        end
        ST_ROOT_WT: begin
          dev_q <= (root > ROOT_W'(DevMax)) ? DevMax : SAMPLE_W'(root);
        end
        default: begin
        end
      endcase
    end
  end

  // Status of the set.
  always_comb begin
    if (snap_q.ovf) begin
      status = STATUS_DROPPED;
    end else if (single) begin
      status = STATUS_SINGLE;
    end else begin
      status = STATUS_OK;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.sample_count <= COUNT_W'(snap_q.cnt);
      out_q.mean         <= mean_q;
      out_q.std_dev      <= dev_q;
      out_q.largest      <= snap_q.largest;
      out_q.smallest     <= snap_q.smallest;
      out_q.status       <= status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
